>>> design/bts_pkg.sv
// Shared types and constants for the bitonic block sorter.
package bts_pkg;

    localparam int VALUE_W = 32;
    localparam int SIZE_W  = 3;

    typedef logic signed [VALUE_W-1:0] value_t;
    typedef logic [SIZE_W-1:0]         size_t;

    localparam size_t SIZE_RESET = 3'd6;
    localparam size_t SIZE_MIN   = 3'd1;
    localparam size_t SIZE_CAP   = 3'd6;

endpackage

>>> design/bts_bank.sv
// One bank of element storage: one write port, one registered read port.
module bts_bank #(
    parameter int ADDR_W = 6
) (
    input  logic                  clk,
    input  logic                  wr_en,
    input  logic [ADDR_W-1:0]     wr_addr,
    input  bts_pkg::value_t       wr_data,
    input  logic                  rd_en,
    input  logic [ADDR_W-1:0]     rd_addr,
    output bts_pkg::value_t       rd_data
);

    bts_pkg::value_t mem [2**ADDR_W];
    bts_pkg::value_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> design/bitonic_sorter.sv
// Bitonic block sorter top level: fill, in-place compare-exchange network, ordered read-out.
//
// Values are taken one per start beat (start high while busy is low) and stored
// until a block of n = 2^size_log2 values is held (size_log2 clamped to 1..6 and
// to log2 of the largest power of two not above MAX_ELEMENTS). The beat that
// completes a block raises busy and launches the bitonic network over the stored
// values: one compare-exchange per cycle, each pass of n/2 pairs followed by an
// idle wait state so the next pass never reads an entry still being written.
// When the sort is done, the n values leave in ascending order, one per cycle on
// strobe, is_last marking the final one. The rate is set by the two element
// banks: each has one read and one write port, and a pair always straddles both
// banks (the bank is the parity of the address bits). The receiver cannot stall:
// every strobe beat is taken as it appears. Write size_log2 on the cfg channel
// (always ready) only while no block is in flight; lowering it mid-fill makes the
// next beat sort just the first n values held.
module bitonic_sorter #(
    parameter int MAX_ELEMENTS = 64
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic signed [31:0]     value,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [2:0]             cfg_data,
    output logic                   strobe,
    output logic signed [31:0]     sorted_value,
    output logic                   is_last
);

    localparam int MAX_LOG2 = $clog2(MAX_ELEMENTS + 1) - 1;
    localparam int AW       = MAX_LOG2;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SORT = 2'd1;
    localparam logic [1:0] ST_WAIT = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    // control registers
    logic [1:0]            state_reg, state_next;
    bts_pkg::size_t        size_log2_reg, size_log2_next;
    logic [AW-1:0]         fill_reg, fill_next;
    bts_pkg::size_t        kl_reg, kl_next;
    bts_pkg::size_t        jl_reg, jl_next;
    logic [AW-1:0]         pair_reg, pair_next;
    logic [AW-1:0]         out_idx_reg, out_idx_next;
    logic                  s1_valid_reg, s1_valid_next;
    logic                  ov_valid_reg, ov_valid_next;
    logic                  ov_last_reg, ov_last_next;

    // payload registers of the compare stage and output stage
    logic [AW-1:0]         s1_i_reg, s1_p_reg;
    logic                  s1_up_reg;
    logic                  ov_bank_reg;

    // block length
    bts_pkg::size_t        size_eff;
    logic [AW:0]           n_len;
    logic [AW:0]           n_m1;
    logic [AW:0]           half_m1;
    logic [AW:0]           fill_sum;
    logic                  accept;

    // pair generation
    logic [AW-1:0]         low_mask;
    logic [AW:0]           i_wide;
    logic [AW-1:0]         pair_i, pair_p;
    logic                  pair_up;
    logic                  pair_bank;

    // compare-exchange
    bts_pkg::value_t       cmp_a, cmp_b, new_i, new_p;
    logic                  s1_bank;
    logic                  do_swap;

    // bank ports
    logic [1:0]            wr_en, rd_en;
    logic [AW-1:0]         wr_addr [2];
    logic [AW-1:0]         rd_addr [2];
    bts_pkg::value_t       wr_data [2];
    bts_pkg::value_t       rd_data [2];

    always_comb
    begin
        size_eff = size_log2_reg;
        if (size_eff < bts_pkg::SIZE_MIN)
        begin
            size_eff = bts_pkg::SIZE_MIN;
        end
        if (size_eff > bts_pkg::SIZE_CAP)
        begin
            size_eff = bts_pkg::SIZE_CAP;
        end
        if (size_eff > bts_pkg::SIZE_W'(MAX_LOG2))
        begin
            size_eff = bts_pkg::SIZE_W'(MAX_LOG2);
        end
    end

    assign n_len    = (AW+1)'(1) << size_eff;
    assign n_m1     = n_len - (AW+1)'(1);
    assign half_m1  = (n_len >> 1) - (AW+1)'(1);
    assign fill_sum = {1'b0, fill_reg} + (AW+1)'(1);
    assign accept   = start && (state_reg == ST_IDLE);

    // insert a zero at bit jl of the pair counter to get the lower index
    assign low_mask  = (AW'(1) << jl_reg) - AW'(1);
    assign i_wide    = ((({1'b0, pair_reg}) >> jl_reg) << (jl_reg + 3'd1))
                       | {1'b0, pair_reg & low_mask};
    assign pair_i    = i_wide[AW-1:0];
    assign pair_p    = pair_i | (AW'(1) << jl_reg);
    assign pair_up   = ((({1'b0, pair_i}) >> kl_reg) & (AW+1)'(1)) == '0;
    assign pair_bank = ^pair_i;

    // compare stage: read data of both banks is valid now
    assign s1_bank = ^s1_i_reg;
    assign cmp_a   = s1_bank ? rd_data[1] : rd_data[0];
    assign cmp_b   = s1_bank ? rd_data[0] : rd_data[1];
    assign do_swap = s1_up_reg ? (cmp_a > cmp_b) : (cmp_b > cmp_a);
    assign new_i   = do_swap ? cmp_b : cmp_a;
    assign new_p   = do_swap ? cmp_a : cmp_b;

    always_comb
    begin
        state_next     = state_reg;
        size_log2_next = size_log2_reg;
        fill_next      = fill_reg;
        kl_next        = kl_reg;
        jl_next        = jl_reg;
        pair_next      = pair_reg;
        out_idx_next   = out_idx_reg;
        s1_valid_next  = 1'b0;
        ov_valid_next  = 1'b0;
        ov_last_next   = 1'b0;

        if (cfg_valid)
        begin
            size_log2_next = cfg_data;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (fill_sum >= n_len)
                    begin
                        // block complete: drop any excess count and start the network
                        fill_next  = '0;
                        state_next = ST_SORT;
                        kl_next    = bts_pkg::SIZE_W'(1);
                        jl_next    = '0;
                        pair_next  = '0;
                    end
                    else
                    begin
                        fill_next = fill_sum[AW-1:0];
                    end
                end
            end
            ST_SORT:
            begin
                s1_valid_next = 1'b1;
                if ({1'b0, pair_reg} == half_m1)
                begin
                    pair_next  = '0;
                    state_next = ST_WAIT;
                    if (jl_reg == '0)
                    begin
                        kl_next = kl_reg + bts_pkg::SIZE_W'(1);
                        jl_next = kl_reg;
                    end
                    else
                    begin
                        jl_next = jl_reg - bts_pkg::SIZE_W'(1);
                    end
                end
                else
                begin
                    pair_next = pair_reg + AW'(1);
                end
            end
            ST_WAIT:
            begin
                // hold in this state so the last writes of the pass land first
                if (kl_reg > size_eff)
                begin
                    state_next   = ST_OUT;
                    out_idx_next = '0;
                end
                else
                begin
                    state_next = ST_SORT;
                end
            end
            ST_OUT:
            begin
                ov_valid_next = 1'b1;
                ov_last_next  = (out_idx_reg == n_m1[AW-1:0]);
                if (out_idx_reg == n_m1[AW-1:0])
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    out_idx_next = out_idx_reg + AW'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            size_log2_reg <= bts_pkg::SIZE_RESET;
            fill_reg      <= '0;
            kl_reg        <= '0;
            jl_reg        <= '0;
            pair_reg      <= '0;
            out_idx_reg   <= '0;
            s1_valid_reg  <= 1'b0;
            ov_valid_reg  <= 1'b0;
            ov_last_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            size_log2_reg <= size_log2_next;
            fill_reg      <= fill_next;
            kl_reg        <= kl_next;
            jl_reg        <= jl_next;
            pair_reg      <= pair_next;
            out_idx_reg   <= out_idx_next;
            s1_valid_reg  <= s1_valid_next;
            ov_valid_reg  <= ov_valid_next;
            ov_last_reg   <= ov_last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_i_reg    <= pair_i;
        s1_p_reg    <= pair_p;
        s1_up_reg   <= pair_up;
        ov_bank_reg <= ^out_idx_reg;
    end

    // bank port steering
    always_comb
    begin
        wr_en      = '0;
        rd_en      = '0;
        wr_addr[0] = '0;
        wr_addr[1] = '0;
        rd_addr[0] = '0;
        rd_addr[1] = '0;
        wr_data[0] = '0;
        wr_data[1] = '0;

        if (accept)
        begin
            wr_en[^fill_reg]   = 1'b1;
            wr_addr[^fill_reg] = fill_reg;
            wr_data[^fill_reg] = value;
        end

        if (s1_valid_reg)
        begin
            wr_en[s1_bank]    = 1'b1;
            wr_addr[s1_bank]  = s1_i_reg;
            wr_data[s1_bank]  = new_i;
            wr_en[~s1_bank]   = 1'b1;
            wr_addr[~s1_bank] = s1_p_reg;
            wr_data[~s1_bank] = new_p;
        end

        if (state_reg == ST_SORT)
        begin
            rd_en               = 2'b11;
            rd_addr[pair_bank]  = pair_i;
            rd_addr[~pair_bank] = pair_p;
        end
        else if (state_reg == ST_OUT)
        begin
            rd_en      = 2'b11;
            rd_addr[0] = out_idx_reg;
            rd_addr[1] = out_idx_reg;
        end
    end

    for (genvar b = 0; b < 2; b++)
    begin : g_bank
        bts_bank #(
            .ADDR_W (AW)
        ) u_bank (
            .clk     (clk),
            .wr_en   (wr_en[b]),
            .wr_addr (wr_addr[b]),
            .wr_data (wr_data[b]),
            .rd_en   (rd_en[b]),
            .rd_addr (rd_addr[b]),
            .rd_data (rd_data[b])
        );
    end

    assign busy         = (state_reg != ST_IDLE);
    assign cfg_ready    = 1'b1;
    assign strobe       = ov_valid_reg;
    assign is_last      = ov_last_reg;
    assign sorted_value = ov_bank_reg ? rd_data[1] : rd_data[0];

    // a compared pair must always fall in different banks
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> ((^s1_i_reg) != (^s1_p_reg)))
        else $error("compare pair maps to one bank");

    assert property (@(posedge clk) disable iff (!rst_n)
        is_last |-> strobe)
        else $error("is_last without strobe");

    assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && is_last) |=> (!strobe && !busy))
        else $error("output continues past the last beat");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT) |=> strobe)
        else $error("read-out cycle produced no beat");

endmodule
